[rtl/core/gdw_pkg.sv]
// Package for the Gaussian distance weight block.
// Holds sizes, codes, state types and the configuration struct.
// No dependencies.
package gdw_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [26:0] SUM_MAX = 27'h7FFFFFF;
    localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;
    localparam logic [3:0] TAYLOR_LAST = 4'd12;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CFG_CENTRE_X,
        CFG_CENTRE_Y,
        CFG_SPREAD,
        CFG_FLOOR
    } gdw_cfg_idx_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_ZERO_SUM,
        STAT_BAD_INDEX,
        STAT_DROPPED
    } gdw_status_t;

    typedef struct packed {
        logic [23:0] centre_x;
        logic [23:0] centre_y;
        logic [15:0] spread;
        logic [15:0] floor_weight;
    } gdw_cfg_t;

    typedef enum logic [2:0] {
        CT_IDLE,
        CT_LOAD,
        CT_REPORT,
        CT_RDATA,
        CT_RDIV,
        CT_REPLY
    } gdw_ctl_state_t;

    typedef enum logic [3:0] {
        WT_IDLE,
        WT_SQX,
        WT_SQY,
        WT_SQRT,
        WT_RSET,
        WT_RDIV,
        WT_KSPLIT,
        WT_TMUL,
        WT_TDIV,
        WT_ROUND,
        WT_DONE
    } gdw_wt_state_t;

endpackage

[rtl/core/gdw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gdw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gdw_weight.sv]
// Sequential weight unit: distance, square root, scaling division and
// exponential by range reduction and a Taylor series, then the floor.
// Depends on gdw_pkg.
module gdw_weight (
    input  logic               clk,
    input  logic               rst_n,
    input  gdw_pkg::gdw_cfg_t  cfg,
    input  logic               start,
    input  logic [23:0]        point_x,
    input  logic [23:0]        point_y,
    output logic               done,
    output logic [15:0]        weight
);

    gdw_pkg::gdw_wt_state_t state_reg, state_next;

    logic [23:0] ax_reg, ay_reg;
    logic [31:0] s2_reg;
    logic [49:0] v_reg, res_reg, bit_reg;
    logic [31:0] rem_reg;
    logic [19:0] q_reg;
    logic        sat_reg;
    logic [4:0]  cnt_reg;
    logic [35:0] big_reg;
    logic [4:0]  k_reg;
    logic [31:0] f_reg, term_reg, num_reg, quo_reg;
    logic [3:0]  drem_reg, n_reg;
    logic [33:0] acc_reg;
    logic [15:0] weight_reg;

    logic [24:0] dx, dy, adx, ady;
    logic [15:0] sp_eff;
    logic [49:0] trial;
    logic        sq_ge;
    logic [32:0] d4, rem2;
    logic        r_ge;
    logic [19:0] q_new;
    logic [36:0] lshift;
    logic        k_ge;
    logic [35:0] big_new;
    logic [3:0]  qd, drem_new;
    logic [31:0] quo_new;
    logic [33:0] e_shift;
    logic [34:0] e_round;
    logic [15:0] w_sat, w_exp, w_fin;

    assign dx = {point_x[23], point_x} - {cfg.centre_x[23], cfg.centre_x};
    assign dy = {point_y[23], point_y} - {cfg.centre_y[23], cfg.centre_y};
    assign adx = dx[24] ? (~dx + 25'd1) : dx;
    assign ady = dy[24] ? (~dy + 25'd1) : dy;
    assign sp_eff = (cfg.spread == 16'd0) ? 16'd1 : cfg.spread;

    assign trial = res_reg + bit_reg;
    assign sq_ge = (v_reg >= trial);

    assign d4 = {4'd0, res_reg[24:0], 4'd0};
    assign rem2 = {rem_reg, 1'b0};
    assign r_ge = (rem2 >= {1'b0, s2_reg});
    assign q_new = {q_reg[18:0], r_ge};

    assign lshift = {5'd0, gdw_pkg::LN2_Q32} << cnt_reg[2:0];
    assign k_ge = ({1'b0, big_reg} >= lshift);
    assign big_new = k_ge ? (big_reg - lshift[35:0]) : big_reg;

    always_comb
    begin : digit_step
        logic [4:0] r2;
        logic [3:0] r;
        r = drem_reg;
        qd = 4'd0;
        for (int i = 3; i >= 0; i--)
        begin
            r2 = {r, num_reg[28 + i]};
            if (r2 >= {1'b0, n_reg})
            begin
                r2 = r2 - {1'b0, n_reg};
                qd[i] = 1'b1;
            end
            r = r2[3:0];
        end
        drem_new = r;
    end

    assign quo_new = {quo_reg[27:0], qd};

    assign e_shift = acc_reg >> k_reg;
    assign e_round = {1'b0, e_shift} + 35'h8000;
    assign w_sat = (|e_round[34:32]) ? gdw_pkg::WEIGHT_MAX : e_round[31:16];
    assign w_exp = sat_reg ? 16'd0 : w_sat;
    assign w_fin = (w_exp < cfg.floor_weight) ? cfg.floor_weight : w_exp;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gdw_pkg::WT_IDLE:
            begin
                if (start)
                begin
                    state_next = gdw_pkg::WT_SQX;
                end
            end
            gdw_pkg::WT_SQX:    state_next = gdw_pkg::WT_SQY;
            gdw_pkg::WT_SQY:    state_next = gdw_pkg::WT_SQRT;
            gdw_pkg::WT_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = gdw_pkg::WT_RSET;
                end
            end
            gdw_pkg::WT_RSET:
            begin
                state_next = (d4 >= {1'b0, s2_reg}) ? gdw_pkg::WT_ROUND : gdw_pkg::WT_RDIV;
            end
            gdw_pkg::WT_RDIV:
            begin
                if (cnt_reg == 5'd19)
                begin
                    state_next = gdw_pkg::WT_KSPLIT;
                end
            end
            gdw_pkg::WT_KSPLIT:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = gdw_pkg::WT_TMUL;
                end
            end
            gdw_pkg::WT_TMUL:   state_next = gdw_pkg::WT_TDIV;
            gdw_pkg::WT_TDIV:
            begin
                if (cnt_reg == 5'd7)
                begin
                    state_next = (n_reg == gdw_pkg::TAYLOR_LAST) ?
                                 gdw_pkg::WT_ROUND : gdw_pkg::WT_TMUL;
                end
            end
            gdw_pkg::WT_ROUND:  state_next = gdw_pkg::WT_DONE;
            gdw_pkg::WT_DONE:   state_next = gdw_pkg::WT_IDLE;
            default:            state_next = gdw_pkg::WT_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == gdw_pkg::WT_DONE);
    end

    assign weight = weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdw_pkg::WT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gdw_pkg::WT_IDLE:
            begin
                ax_reg <= adx[23:0];
                ay_reg <= ady[23:0];
            end
            gdw_pkg::WT_SQX:
            begin
                v_reg <= {26'd0, ax_reg} * {26'd0, ax_reg};
                s2_reg <= sp_eff * sp_eff;
            end
            gdw_pkg::WT_SQY:
            begin
                v_reg <= v_reg + ({26'd0, ay_reg} * {26'd0, ay_reg});
                res_reg <= 50'd0;
                bit_reg <= 50'd1 << 48;
            end
            gdw_pkg::WT_SQRT:
            begin
                if (sq_ge)
                begin
                    v_reg <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            gdw_pkg::WT_RSET:
            begin
                sat_reg <= (d4 >= {1'b0, s2_reg});
                rem_reg <= d4[31:0];
                q_reg <= 20'd0;
                cnt_reg <= 5'd0;
            end
            gdw_pkg::WT_RDIV:
            begin
                rem_reg <= r_ge ? 32'(rem2 - {1'b0, s2_reg}) : rem2[31:0];
                q_reg <= q_new;
                cnt_reg <= cnt_reg + 5'd1;
                big_reg <= {q_new, 16'd0};
                k_reg <= 5'd0;
                if (cnt_reg == 5'd19)
                begin
                    cnt_reg <= 5'd4;
                end
            end
            gdw_pkg::WT_KSPLIT:
            begin
                big_reg <= big_new;
                k_reg[cnt_reg[2:0]] <= k_ge;
                cnt_reg <= cnt_reg - 5'd1;
                f_reg <= big_new[31:0];
                term_reg <= big_new[31:0];
                acc_reg <= 34'h100000000 - {2'd0, big_new[31:0]};
                n_reg <= 4'd2;
            end
            gdw_pkg::WT_TMUL:
            begin
                num_reg <= 32'(({32'd0, term_reg} * {32'd0, f_reg}) >> 32);
                drem_reg <= 4'd0;
                quo_reg <= 32'd0;
                cnt_reg <= 5'd0;
            end
            gdw_pkg::WT_TDIV:
            begin
                num_reg <= num_reg << 4;
                drem_reg <= drem_new;
                quo_reg <= quo_new;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                begin
                    term_reg <= quo_new;
                    n_reg <= n_reg + 4'd1;
                    if (n_reg[0])
                    begin
                        acc_reg <= acc_reg - {2'd0, quo_new};
                    end
                    else
                    begin
                        acc_reg <= acc_reg + {2'd0, quo_new};
                    end
                end
            end
            gdw_pkg::WT_ROUND:
            begin
                weight_reg <= w_fin;
            end
            gdw_pkg::WT_DONE:
            begin
                weight_reg <= weight_reg;
            end
            default:
            begin
                weight_reg <= weight_reg;
            end
        endcase
    end

endmodule

[rtl/core/gaussian_distance_weights.sv]
// Top level of the Gaussian distance weight block: configuration registers,
// batch control, weight memory and the read-back divider.
// Depends on gdw_pkg, gdw_ram and gdw_weight.
//
//   channel   handshake            payload
//   --------  -------------------  ---------------------------------------------
//   config    wr_en                wr_index, wr_data
//   item in   start & !busy        mode, point_x, point_y, last_point, read_index
//   result    done (one cycle)     kind, weight, total, point_count, status
//
// A load item passes through the weight unit in 2 squaring steps, 25 square
// root steps, 20 division steps, 5 range reduction steps, 11 series terms of
// one multiply and eight 4-bit division steps each, and 2 for rounding and
// handoff. When the scaled distance reaches 16 the division, range reduction
// and series are skipped. A last load also passes through the report state.
// A read item passes through the one-bit-per-cycle divider for its sixteen
// quotient bits, or goes straight to the reply when its status is not ok.
// Reset clears the control state and counts at once; the weight memory is
// not cleared. Results cannot be stalled; the next item is taken during done.
module gaussian_distance_weights (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [23:0] point_x,
    input  logic [23:0] point_y,
    input  logic        last_point,
    input  logic [9:0]  read_index,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [23:0] wr_data,
    output logic        done,
    output logic        kind,
    output logic [15:0] weight,
    output logic [26:0] total,
    output logic [10:0] point_count,
    output logic [1:0]  status
);

    gdw_pkg::gdw_ctl_state_t state_reg, state_next;
    gdw_pkg::gdw_cfg_t       cfg_reg;

    logic [gdw_pkg::CNT_W-1:0] count_reg;
    logic [26:0] sum_reg;
    logic        closed_reg, dropped_reg, last_reg;
    logic [1:0]  rstat_reg;
    logic [26:0] drem_reg;
    logic [15:0] dlo_reg, dq_reg;
    logic        dsat_reg;
    logic [3:0]  dcnt_reg;
    logic        done_reg, kind_reg;
    logic [15:0] weight_reg;
    logic [1:0]  status_reg;

    logic        accept, wt_start, wt_done, ram_we, has_room;
    logic [15:0] wt_weight, ram_rdata;
    logic [1:0]  rd_status, rep_status;
    logic [27:0] sum_add, r2;
    logic [32:0] dividend;
    logic        r_ge;

    assign accept = start && (state_reg == gdw_pkg::CT_IDLE);
    assign has_room = (count_reg < gdw_pkg::CNT_W'(gdw_pkg::MAX_POINTS));
    assign sum_add = {1'b0, sum_reg} + {12'd0, wt_weight};

    always_comb
    begin
        priority if (dropped_reg)
        begin
            rd_status = gdw_pkg::STAT_DROPPED;
        end
        else if (32'(read_index) >= 32'(count_reg))
        begin
            rd_status = gdw_pkg::STAT_BAD_INDEX;
        end
        else if (sum_reg == 27'd0)
        begin
            rd_status = gdw_pkg::STAT_ZERO_SUM;
        end
        else
        begin
            rd_status = gdw_pkg::STAT_OK;
        end
    end

    always_comb
    begin
        priority if (dropped_reg)
        begin
            rep_status = gdw_pkg::STAT_DROPPED;
        end
        else if (sum_reg == 27'd0)
        begin
            rep_status = gdw_pkg::STAT_ZERO_SUM;
        end
        else
        begin
            rep_status = gdw_pkg::STAT_OK;
        end
    end

    assign dividend = {1'b0, ram_rdata, 16'd0} + {7'd0, sum_reg[26:1]};
    assign r2 = {drem_reg, dlo_reg[15]};
    assign r_ge = (r2 >= {1'b0, sum_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gdw_pkg::CT_IDLE:
            begin
                if (accept)
                begin
                    if (mode == gdw_pkg::MODE_LOAD)
                    begin
                        state_next = gdw_pkg::CT_LOAD;
                    end
                    else if (rd_status == gdw_pkg::STAT_OK)
                    begin
                        state_next = gdw_pkg::CT_RDATA;
                    end
                    else
                    begin
                        state_next = gdw_pkg::CT_REPLY;
                    end
                end
            end
            gdw_pkg::CT_LOAD:
            begin
                if (wt_done)
                begin
                    state_next = last_reg ? gdw_pkg::CT_REPORT : gdw_pkg::CT_IDLE;
                end
            end
            gdw_pkg::CT_REPORT: state_next = gdw_pkg::CT_IDLE;
            gdw_pkg::CT_RDATA:  state_next = gdw_pkg::CT_RDIV;
            gdw_pkg::CT_RDIV:
            begin
                if (dcnt_reg == 4'd15)
                begin
                    state_next = gdw_pkg::CT_REPLY;
                end
            end
            gdw_pkg::CT_REPLY:  state_next = gdw_pkg::CT_IDLE;
            default:            state_next = gdw_pkg::CT_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != gdw_pkg::CT_IDLE);
        wt_start = accept && (mode == gdw_pkg::MODE_LOAD);
        ram_we = (state_reg == gdw_pkg::CT_LOAD) && wt_done && has_room;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdw_pkg::CT_IDLE;
            cfg_reg.centre_x <= 24'd0;
            cfg_reg.centre_y <= 24'd0;
            cfg_reg.spread <= 16'd256;
            cfg_reg.floor_weight <= 16'd164;
            count_reg <= '0;
            sum_reg <= 27'd0;
            closed_reg <= 1'b0;
            dropped_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == gdw_pkg::CT_REPORT) ||
                        (state_reg == gdw_pkg::CT_REPLY);
            if (wr_en)
            begin
                unique case (gdw_pkg::gdw_cfg_idx_t'(wr_index))
                    gdw_pkg::CFG_CENTRE_X: cfg_reg.centre_x <= wr_data;
                    gdw_pkg::CFG_CENTRE_Y: cfg_reg.centre_y <= wr_data;
                    gdw_pkg::CFG_SPREAD:   cfg_reg.spread <= wr_data[15:0];
                    gdw_pkg::CFG_FLOOR:    cfg_reg.floor_weight <= wr_data[15:0];
                    default:               cfg_reg <= cfg_reg;
                endcase
            end
            if (wt_start && closed_reg)
            begin
                count_reg <= '0;
                sum_reg <= 27'd0;
                dropped_reg <= 1'b0;
                closed_reg <= 1'b0;
            end
            if ((state_reg == gdw_pkg::CT_LOAD) && wt_done)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg <= sum_add[27] ? gdw_pkg::SUM_MAX : sum_add[26:0];
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
                if (last_reg)
                begin
                    closed_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_point;
            rstat_reg <= rd_status;
        end
        if (state_reg == gdw_pkg::CT_RDATA)
        begin
            dsat_reg <= ({10'd0, dividend} >= {sum_reg, 16'd0});
            drem_reg <= 27'(dividend[32:16]);
            dlo_reg <= dividend[15:0];
            dq_reg <= 16'd0;
            dcnt_reg <= 4'd0;
        end
        if (state_reg == gdw_pkg::CT_RDIV)
        begin
            drem_reg <= r_ge ? 27'(r2 - {1'b0, sum_reg}) : r2[26:0];
            dlo_reg <= dlo_reg << 1;
            dq_reg <= {dq_reg[14:0], r_ge};
            dcnt_reg <= dcnt_reg + 4'd1;
        end
        if (state_reg == gdw_pkg::CT_REPORT)
        begin
            kind_reg <= gdw_pkg::KIND_REPORT;
            weight_reg <= 16'd0;
            status_reg <= rep_status;
        end
        if (state_reg == gdw_pkg::CT_REPLY)
        begin
            kind_reg <= gdw_pkg::KIND_WEIGHT;
            status_reg <= rstat_reg;
            if (rstat_reg == gdw_pkg::STAT_OK)
            begin
                weight_reg <= dsat_reg ? gdw_pkg::WEIGHT_MAX : dq_reg;
            end
            else
            begin
                weight_reg <= 16'd0;
            end
        end
    end

    gdw_weight u_weight (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .start   (wt_start),
        .point_x (point_x),
        .point_y (point_y),
        .done    (wt_done),
        .weight  (wt_weight)
    );

    gdw_ram #(
        .WIDTH (16),
        .DEPTH (gdw_pkg::MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[gdw_pkg::IDX_W-1:0]),
        .wdata (wt_weight),
        .raddr (gdw_pkg::IDX_W'(read_index)),
        .rdata (ram_rdata)
    );

    assign done = done_reg;
    assign kind = kind_reg;
    assign weight = weight_reg;
    assign total = sum_reg;
    assign point_count = 11'(count_reg);
    assign status = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == gdw_pkg::CT_REPORT ||
                      $past(state_reg) == gdw_pkg::CT_REPLY))
        else $error("result strobe without a finished item");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gdw_pkg::CNT_W'(gdw_pkg::MAX_POINTS))
        else $error("point count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != gdw_pkg::STAT_OK) |-> (weight_reg == 16'd0))
        else $error("nonzero weight with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wt_start && closed_reg) |=> (count_reg == '0 && !dropped_reg))
        else $error("new batch did not clear the count");

endmodule

[tb/sv/gaussian_distance_weights_tb.sv]
// Testbench for gaussian_distance_weights: directed and random batches of loads and reads.
// A predictor in this file computes the expected report or read-back for each item that gives a result.
// Depends on gdw_pkg and the gaussian_distance_weights RTL.
`timescale 1ns / 100ps

module gaussian_distance_weights_tb;

    typedef struct {
        logic        kind;
        logic [15:0] weight;
        logic [26:0] total;
        logic [10:0] point_count;
        logic [1:0]  status;
    } gdw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        mode = gdw_pkg::MODE_LOAD;
    logic [23:0] point_x = '0;
    logic [23:0] point_y = '0;
    logic        last_point = 1'b0;
    logic [9:0]  read_index = '0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = gdw_pkg::CFG_CENTRE_X;
    logic [23:0] wr_data = '0;
    logic        done;
    logic        kind;
    logic [15:0] weight;
    logic [26:0] total;
    logic [10:0] point_count;
    logic [1:0]  status;

    gdw_pkg::gdw_cfg_t cfg;
    logic [15:0] weight_mem [gdw_pkg::MAX_POINTS];
    int          n_stored;
    longint      batch_sum;
    bit          closed;
    bit          dropped;
    gdw_result_t pending_q[$];
    int          errors = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    gaussian_distance_weights DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .point_x(point_x), .point_y(point_y), .last_point(last_point),
        .read_index(read_index), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .done(done), .kind(kind), .weight(weight),
        .total(total), .point_count(point_count), .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] gauss_weight(logic [23:0] px, logic [23:0] py);
        longint dx = longint'($signed(px)) - longint'($signed(cfg.centre_x));
        longint dy = longint'($signed(py)) - longint'($signed(cfg.centre_y));
        longint unsigned ax = dx < 0 ? -dx : dx;
        longint unsigned ay = dy < 0 ? -dy : dy;
        longint unsigned d = int_sqrt(ax * ax + ay * ay);
        longint unsigned sp = (cfg.spread == 0) ? 1 : cfg.spread;
        longint unsigned r = (d << 24) / (sp * sp);
        longint unsigned big, k, f, term, acc, e;
        logic [15:0] w;
        if (r >= (64'd16 << 16))
            w = 0;
        else
        begin
            big = r << 16;
            k = big / gdw_pkg::LN2_Q32;
            f = big - k * gdw_pkg::LN2_Q32;
            term = 64'd1 << 32;
            acc = term;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * f) >> 32) / n;
                if (n % 2 == 1)
                    acc -= term;
                else
                    acc += term;
            end
            e = ((acc >> k) + 64'h8000) >> 16;
            w = (e > 65535) ? gdw_pkg::WEIGHT_MAX : e[15:0];
        end
        if (w < cfg.floor_weight)
            w = cfg.floor_weight;
        return w;
    endfunction

    task automatic predict_item();
        gdw_result_t res;
        logic [15:0] w;
        longint unsigned q;
        res.weight = 0;
        res.status = gdw_pkg::STAT_OK;
        if (mode == gdw_pkg::MODE_LOAD)
        begin
            if (closed)
            begin
                n_stored = 0;
                batch_sum = 0;
                dropped = 0;
                closed = 0;
            end
            w = gauss_weight(point_x, point_y);
            if (n_stored < gdw_pkg::MAX_POINTS)
            begin
                weight_mem[n_stored] = w;
                n_stored++;
                batch_sum += w;
                if (batch_sum > gdw_pkg::SUM_MAX)
                    batch_sum = gdw_pkg::SUM_MAX;
            end
            else
                dropped = 1;
            if (!last_point)
                return;
            closed = 1;
            if (dropped)
                res.status = gdw_pkg::STAT_DROPPED;
            else if (batch_sum == 0)
                res.status = gdw_pkg::STAT_ZERO_SUM;
            res.kind = gdw_pkg::KIND_REPORT;
        end
        else
        begin
            if (dropped)
                res.status = gdw_pkg::STAT_DROPPED;
            else if (read_index >= n_stored)
                res.status = gdw_pkg::STAT_BAD_INDEX;
            else if (batch_sum == 0)
                res.status = gdw_pkg::STAT_ZERO_SUM;
            else
            begin
                q = (longint'(weight_mem[read_index]) * 65536 + batch_sum / 2)
                    / batch_sum;
                res.weight = (q > 65535) ? gdw_pkg::WEIGHT_MAX : q[15:0];
            end
            res.kind = gdw_pkg::KIND_WEIGHT;
        end
        res.total = batch_sum[26:0];
        res.point_count = n_stored[10:0];
        pending_q.push_back(res);
    endtask

    // Called at a rising edge; leaves start high when the next item follows at once.
    task automatic send_item(logic m, logic [23:0] px, logic [23:0] py, logic lp,
                             logic [9:0] idx);
        start <= 1'b1;
        mode <= m;
        point_x <= px;
        point_y <= py;
        last_point <= lp;
        read_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Waits until the block is idle so that no item in flight sees the new value.
    task automatic write_reg(gdw_pkg::gdw_cfg_idx_t idx, logic [23:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            gdw_pkg::CFG_CENTRE_X: cfg.centre_x = data;
            gdw_pkg::CFG_CENTRE_Y: cfg.centre_y = data;
            gdw_pkg::CFG_SPREAD:   cfg.spread = data[15:0];
            default:               cfg.floor_weight = data[15:0];
        endcase
    endtask

    function automatic logic [23:0] near_coord(logic [23:0] c);
        int span = 4 * ((cfg.spread == 0) ? 1 : int'(cfg.spread));
        int off = int'($urandom_range(0, span)) - span / 2;
        return c + off[23:0];
    endfunction

    task automatic read_any();
        logic [9:0] idx;
        if ($urandom_range(0, 3) == 0 || n_stored == 0)
            idx = 10'($urandom_range(0, 1023));
        else
            idx = 10'($urandom_range(0, n_stored - 1));
        send_item(gdw_pkg::MODE_READ, 24'($urandom), 24'($urandom), 1'($urandom), idx);
    endtask

    task automatic test_defaults();
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h0, 24'h0, 1'b0, 10'h3FF);
        send_item(gdw_pkg::MODE_LOAD, 24'h7FFFFF, 24'h800000, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h800000, 24'h7FFFFF, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h000100, 24'hFFFF00, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd3);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd4);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'h3FF);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(gdw_pkg::CFG_CENTRE_X, 24'h7FFFFF);
        write_reg(gdw_pkg::CFG_CENTRE_Y, 24'h800000);
        write_reg(gdw_pkg::CFG_SPREAD, 24'd1);
        write_reg(gdw_pkg::CFG_FLOOR, 24'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h0, 24'h0, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h800000, 24'h7FFFFF, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h7FFFFF, 24'h800000, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd0);
        drain();
        write_reg(gdw_pkg::CFG_SPREAD, 24'd0);
        write_reg(gdw_pkg::CFG_FLOOR, 24'hFFFF);
        send_item(gdw_pkg::MODE_LOAD, 24'h7FFFFF, 24'h800001, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h0, 24'h0, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd1);
        drain();
        write_reg(gdw_pkg::CFG_SPREAD, 24'hFFFF);
        write_reg(gdw_pkg::CFG_FLOOR, 24'd164);
        write_reg(gdw_pkg::CFG_CENTRE_X, 24'h0);
        write_reg(gdw_pkg::CFG_CENTRE_Y, 24'h0);
        send_item(gdw_pkg::MODE_LOAD, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 10'd0);
        send_item(gdw_pkg::MODE_LOAD, 24'h800000, 24'h800000, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd0);
        drain();
    endtask

    task automatic test_capacity();
        write_reg(gdw_pkg::CFG_SPREAD, 24'd2048);
        for (int i = 0; i <= gdw_pkg::MAX_POINTS; i++)
            send_item(gdw_pkg::MODE_LOAD, near_coord(cfg.centre_x),
                      near_coord(cfg.centre_y), i == gdw_pkg::MAX_POINTS, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd5);
        send_item(gdw_pkg::MODE_LOAD, 24'h0, 24'h0, 1'b1, 10'd0);
        send_item(gdw_pkg::MODE_READ, 24'h0, 24'h0, 1'b0, 10'd0);
        drain();
    endtask

    task automatic test_random_batches();
        int batch_len;
        for (int b = 0; b < 65; b++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(gdw_pkg::CFG_CENTRE_X, 24'($urandom));
                write_reg(gdw_pkg::CFG_CENTRE_Y, 24'($urandom));
                write_reg(gdw_pkg::CFG_SPREAD, $urandom_range(0, 3) == 0 ?
                          24'($urandom) : 24'($urandom_range(1, 4096)));
                write_reg(gdw_pkg::CFG_FLOOR, $urandom_range(0, 3) == 0 ?
                          24'($urandom) : 24'($urandom_range(0, 400)));
            end
            batch_len = $urandom_range(1, 10);
            for (int i = 0; i < batch_len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    read_any();
                if ($urandom_range(0, 3) == 0)
                    send_item(gdw_pkg::MODE_LOAD, 24'($urandom), 24'($urandom),
                              i == batch_len - 1, 10'($urandom));
                else
                    send_item(gdw_pkg::MODE_LOAD, near_coord(cfg.centre_x),
                              near_coord(cfg.centre_y), i == batch_len - 1,
                              10'($urandom));
            end
            repeat ($urandom_range(1, 6)) read_any();
            if (b % 10 == 9)
                drain();
        end
        drain();
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        gdw_result_t res;
        if (done)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind);
                errors++;
            end
            else
            begin
                res = pending_q.pop_front();
                check_field("kind", res.kind, kind);
                check_field("weight", res.weight, weight);
                check_field("total", res.total, total);
                check_field("point_count", res.point_count, point_count);
                check_field("status", res.status, status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("FAIL gaussian_distance_weights");
            $finish;
        end
    end

    initial
    begin
        cfg = '{centre_x: 24'h0, centre_y: 24'h0, spread: 16'd256, floor_weight: 16'd164};
        n_stored = 0;
        batch_sum = 0;
        closed = 0;
        dropped = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_config_extremes();
        test_capacity();
        test_random_batches();
        if (pending_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_q.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS gaussian_distance_weights");
        else
            $display("FAIL gaussian_distance_weights");
        $finish;
    end
endmodule

[sim.f]
rtl/core/gdw_pkg.sv
rtl/core/gdw_ram.sv
rtl/core/gdw_weight.sv
rtl/core/gaussian_distance_weights.sv
tb/sv/gaussian_distance_weights_tb.sv
